// ----- hdl/mmbd_pkg.sv -----
// shared types and constants for the 2x2 mipmap box downsampler
// no dependencies; imported by every module of the block
package mmbd_pkg;

   localparam int LANES          = 4;
   localparam int CHAN_BITS      = 8;
   localparam int SUM_BITS       = CHAN_BITS + 1;
   localparam int DIM_BITS       = 12;
   localparam int COUNT_BITS     = 3;
   localparam int CSR_IDX_BITS   = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam int MAX_WIDTH_DEF  = 2048;

   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 12'd256;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 12'd256;
   localparam logic [COUNT_BITS-1:0] COUNT_RESET  = 3'd4;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_IMAGE_WIDTH     = 2'd0,
      CSR_IMAGE_HEIGHT    = 2'd1,
      CSR_COMPONENT_COUNT = 2'd2
   } csr_index_type;

   // per-transfer decode from the position tracker to the datapath
   typedef struct packed {
      logic             held_load;  // capture this pixel as left/top half of a pair
      logic             sum_wr;     // store pair sums of an even row
      logic             emit;       // this transfer produces a result
      logic             done;       // last result of the reduced image
      logic             is_2d;      // four-pixel average instead of a pair average
      logic [LANES-1:0] lane_en;    // components in use
   } mmbd_ctrl_type;

endpackage

// ----- hdl/mmbd_line_buf.sv -----
// line buffer holding the pair sums of the even row
// uses mmbd_pkg; one write port, one registered read port
module mmbd_line_buf #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 36
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);
   import mmbd_pkg::*;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mmbd_lane.sv -----
// one component lane: pair sum, held pixel, and the final average
// uses mmbd_pkg for channel and sum widths
module mmbd_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          held_load,
   input  logic                          s1_load,
   input  logic [mmbd_pkg::CHAN_BITS-1:0] px,
   input  logic [mmbd_pkg::SUM_BITS-1:0]  top,
   input  logic                          is_2d,
   output logic [mmbd_pkg::SUM_BITS-1:0]  pair_sum,
   output logic [mmbd_pkg::CHAN_BITS-1:0] result
);
   import mmbd_pkg::*;

   logic [CHAN_BITS-1:0] held_ff;
   logic [SUM_BITS-1:0]  sum_ff;
   logic [SUM_BITS:0]    quad;

   assign pair_sum = {1'b0, held_ff} + {1'b0, px};

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else if (held_load) begin
         held_ff <= px;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         sum_ff <= pair_sum;
      end
   end

   assign quad = {1'b0, top} + {1'b0, sum_ff};

   always_comb begin
      if (is_2d) begin
         result = quad[SUM_BITS:2];
      end else begin
         result = sum_ff[SUM_BITS-1:1];
      end
   end

endmodule

// ----- hdl/mmbd_ctrl.sv -----
// configuration registers, raster position and per-transfer decode
// uses mmbd_pkg for the csr codes and the control struct
module mmbd_ctrl #(
   parameter int MAX_WIDTH = mmbd_pkg::MAX_WIDTH_DEF,
   parameter int CW        = $clog2(MAX_WIDTH),
   parameter int AW        = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [mmbd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mmbd_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  logic                              accept,
   output mmbd_pkg::mmbd_ctrl_type           ctrl,
   output logic [AW-1:0]                     idx
);
   import mmbd_pkg::*;

   localparam int WW = CW + 1;

   logic [DIM_BITS-1:0]   width_ff, height_ff;
   logic [COUNT_BITS-1:0] count_ff;
   logic [CW-1:0]         col_ff, col_in;
   logic [DIM_BITS-1:0]   row_ff, row_in;

   logic [31:0]         w32;
   logic [WW-1:0]       w, wl, colx, colp1;
   logic [DIM_BITS-1:0] h, hl;
   logic [DIM_BITS:0]   rowp1;
   logic [CW-1:0]       half;
   logic [2:0]          cc;
   logic in_img, one_d, horiz, pos_in, pos_odd, pos_last, in_2d, pair;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         count_ff  <= COUNT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:     width_ff  <= csr_write_data[DIM_BITS-1:0];
            CSR_IMAGE_HEIGHT:    height_ff <= csr_write_data[DIM_BITS-1:0];
            CSR_COMPONENT_COUNT: count_ff  <= csr_write_data[COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // effective geometry
   always_comb begin
      w32 = (width_ff == '0) ? 32'd1 : {{(32-DIM_BITS){1'b0}}, width_ff};
      if (w32 > MAX_WIDTH) begin
         w32 = MAX_WIDTH;
      end
      w     = w32[WW-1:0];
      h     = (height_ff == '0) ? DIM_BITS'(1) : height_ff;
      wl    = {w[WW-1:1], 1'b0};
      hl    = {h[DIM_BITS-1:1], 1'b0};
      cc    = (count_ff == '0) ? 3'd1 : ((count_ff > 3'd4) ? 3'd4 : count_ff);
      colx  = {1'b0, col_ff};
      colp1 = colx + WW'(1);
      rowp1 = {1'b0, row_ff} + (DIM_BITS+1)'(1);
   end

   // classification of the current position
   always_comb begin
      in_img   = (colx < w) && (row_ff < h) && !((w == WW'(1)) && (h == DIM_BITS'(1)));
      one_d    = (h == DIM_BITS'(1)) || (w == WW'(1));
      horiz    = (h == DIM_BITS'(1));
      pos_in   = horiz ? (colx < wl) : (row_ff < hl);
      pos_odd  = horiz ? col_ff[0] : row_ff[0];
      pos_last = horiz ? (colx == wl - WW'(1)) : (row_ff == hl - DIM_BITS'(1));
      in_2d    = !one_d && (colx < wl) && (row_ff < hl);
      pair     = in_img && ((one_d && pos_in && pos_odd) || (in_2d && col_ff[0]));

      ctrl.held_load = accept && in_img &&
                       ((one_d && pos_in && !pos_odd) || (in_2d && !col_ff[0]));
      ctrl.sum_wr    = accept && pair && !one_d && !row_ff[0];
      ctrl.emit      = accept && pair && (one_d || row_ff[0]);
      ctrl.done      = one_d ? pos_last :
                       ((colx == wl - WW'(1)) && (row_ff == hl - DIM_BITS'(1)));
      ctrl.is_2d     = !one_d;
      for (int i = 0; i < LANES; i++) begin
         ctrl.lane_en[i] = (i < int'(cc));
      end
      half = col_ff >> 1;
      idx  = half[AW-1:0];
   end

   // raster advance
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (colp1 >= w) begin
         col_in = '0;
         row_in = (rowp1 >= {1'b0, h}) ? '0 : rowp1[DIM_BITS-1:0];
      end else if (row_ff >= h) begin
         col_in = '0;
         row_in = '0;
      end else begin
         col_in = colp1[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// ----- hdl/mipmap_box_downsample_top.sv -----
// top level of the 2x2 box-filter mipmap downsampler
// uses mmbd_pkg, mmbd_ctrl, mmbd_lane and mmbd_line_buf
//
// Takes one source pixel per transfer in raster order and returns one reduced
// pixel per complete 2x2 block; a one-row or one-column image averages pairs
// along its long axis, and an odd last row or column is swallowed. Throughput
// is one pixel per clock with no gaps while the output is not stalled: the only
// loop is the raster counter, and the line buffer is a single-write, single-read
// memory with a registered read. A transfer passes stage 1 (pair sums, line buffer
// read) and the output register before its result is offered. The user must see that
// width, height and component count are written through the csr port only while no
// frame is in flight; the block does not enforce it. The line buffer needs no
// clearing after reset: every odd-row read hits an entry written earlier in that frame.
module mipmap_box_downsample_top #(
   parameter int MAX_WIDTH = mmbd_pkg::MAX_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [mmbd_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [mmbd_pkg::CSR_DATA_BITS-1:0] csr_write_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [mmbd_pkg::CHAN_BITS-1:0]     req_chan0,
   input  logic [mmbd_pkg::CHAN_BITS-1:0]     req_chan1,
   input  logic [mmbd_pkg::CHAN_BITS-1:0]     req_chan2,
   input  logic [mmbd_pkg::CHAN_BITS-1:0]     req_chan3,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [mmbd_pkg::CHAN_BITS-1:0]     rsp_out0,
   output logic [mmbd_pkg::CHAN_BITS-1:0]     rsp_out1,
   output logic [mmbd_pkg::CHAN_BITS-1:0]     rsp_out2,
   output logic [mmbd_pkg::CHAN_BITS-1:0]     rsp_out3,
   output logic                              rsp_frame_done
);
   import mmbd_pkg::*;

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int DEPTH = MAX_WIDTH / 2;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int DW    = LANES * SUM_BITS;

   mmbd_ctrl_type ctrl;
   logic [AW-1:0] idx;

   logic accept, s1_adv, out_load;

   // stage 1: pair sums held in lanes, line buffer read in flight
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_done_ff;
   logic             s1_2d_ff;
   logic [LANES-1:0] s1_mask_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_done_ff;
   logic [CHAN_BITS-1:0] rsp_data_ff [LANES];

   logic [CHAN_BITS-1:0] px     [LANES];
   logic [CHAN_BITS-1:0] chan   [LANES];
   logic [CHAN_BITS-1:0] result [LANES];
   logic [DW-1:0]        wr_data, rd_data;

   // handshake: output slot frees stage 1, stage 1 frees the input
   assign out_load    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv      = out_load || !s1_valid_ff;
   assign req_stall   = !s1_adv;
   assign accept      = req_valid && !req_stall;
   assign s1_valid_in = ctrl.emit;
   assign rsp_valid_in = s1_valid_ff;

   assign chan[0] = req_chan0;
   assign chan[1] = req_chan1;
   assign chan[2] = req_chan2;
   assign chan[3] = req_chan3;

   mmbd_ctrl #(
      .MAX_WIDTH (MAX_WIDTH),
      .CW        (CW),
      .AW        (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .accept         (accept),
      .ctrl           (ctrl),
      .idx            (idx)
   );

   // one lane per component; unused components enter as zero
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      assign px[i] = ctrl.lane_en[i] ? chan[i] : '0;

      mmbd_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .held_load (ctrl.held_load),
         .s1_load   (s1_adv),
         .px        (px[i]),
         .top       (rd_data[i*SUM_BITS +: SUM_BITS]),
         .is_2d     (s1_2d_ff),
         .pair_sum  (wr_data[i*SUM_BITS +: SUM_BITS]),
         .result    (result[i])
      );
   end

   // even-row pair sums, read back on the matching odd-row transfer
   mmbd_line_buf #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .DW    (DW)
   ) u_line_buf (
      .clock   (clock),
      .wr_en   (ctrl.sum_wr),
      .wr_addr (idx),
      .wr_data (wr_data),
      .rd_en   (s1_adv),
      .rd_addr (idx),
      .rd_data (rd_data)
   );

   // stage 1 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_done_ff <= ctrl.done;
         s1_2d_ff   <= ctrl.is_2d;
         s1_mask_ff <= ctrl.lane_en;
      end
   end

   // merge the lanes into the output register, unused components forced to zero
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_done_ff <= s1_done_ff;
         for (int i = 0; i < LANES; i++) begin
            rsp_data_ff[i] <= s1_mask_ff[i] ? result[i] : '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out0       = rsp_data_ff[0];
   assign rsp_out1       = rsp_data_ff[1];
   assign rsp_out2       = rsp_data_ff[2];
   assign rsp_out3       = rsp_data_ff[3];
   assign rsp_frame_done = rsp_done_ff;

endmodule
